// File: hw/rtl/dfh_pkg.sv
// Shared types and constants for the dual FNV-1a word hasher.
// Holds lane constants, the controller state type and the command struct.
// Depends on nothing; imported by the controller, the datapath and the top level.
package dfh_pkg;

    localparam int WORD_W = 64;
    localparam int BYTE_W = 8;
    localparam int HALF_W = WORD_W / 2;
    localparam int BYTES_PER_WORD = WORD_W / BYTE_W;
    localparam int CNT_W = $clog2(BYTES_PER_WORD);
    localparam int LANES = 2;

    // Lane zero is standard FNV-1a 64; lane one uses its own basis and prime.
    localparam logic [WORD_W-1:0] LANE_OFFSET [LANES] = '{
        64'd14695981039346656037,
        64'd7809847782465536322
    };
    localparam logic [WORD_W-1:0] LANE_PRIME [LANES] = '{
        64'd1099511628211,
        64'd14029467366897019727
    };

    // Controller states, one-hot coded.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_ADD  = 4'b0100,
        ST_DONE = 4'b1000
    } dfh_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // take a new word from the input transaction
        logic start;     // reload the offset bases with this word
        logic mul;       // capture the partial products of one round
        logic add;       // fold the partial products into the accumulators
        logic load_out;  // copy both accumulators into the output register
    } dfh_cmd_t;

endpackage

// File: hw/rtl/dual_fnv1a_word_hasher.sv
// Dual FNV-1a word hasher: a new 64-bit word is accepted only after the previous
// one is finished, and a word with the last flag waits until the output is free.
// The pace is set by the multiplier in each lane: eight byte rounds per word,
// each a partial-product step then a sum step, plus an accept state and a finish
// state. Reset loads both accumulators with their offset bases and empties the
// output register; the block is ready at once.
module dual_fnv1a_word_hasher
    import dfh_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [WORD_W-1:0]   s_tdata,   // word
    input  logic                s_tuser,   // start_req
    input  logic                s_tlast,   // last
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [2*WORD_W-1:0] m_tdata    // second_hash (high), first_hash (low)
);

    dfh_cmd_t          cmd;
    logic [WORD_W-1:0] first_hash;
    logic [WORD_W-1:0] second_hash;

    // Sequencer for rounds and handshakes.
    dfh_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Accumulator lanes and output register.
    dfh_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .word        (s_tdata),
        .first_hash  (first_hash),
        .second_hash (second_hash)
    );

    assign m_tdata = {second_hash, first_hash};

endmodule

// File: hw/rtl/dfh_ctrl.sv
// Controller of the dual FNV-1a word hasher.
// Sequences eight capture-and-fold rounds per word and owns both handshakes.
// Depends on dfh_pkg for the state type and the command struct.
module dfh_ctrl
    import dfh_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic     s_tuser,
    input  logic     s_tlast,
    output logic     m_tvalid,
    input  logic     m_tready,
    output dfh_cmd_t cmd
);

    dfh_state_t       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             last_reg, last_next;
    logic             out_valid_reg, out_valid_next;
    logic             accept;
    logic             out_free;

    // An input transaction is taken only between words.
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign out_free = !out_valid_reg || m_tready;

    // Next-state and command logic.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        last_next    = last_reg;
        cmd          = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    cmd.start  = s_tuser;
                    last_next  = s_tlast;
                    cnt_next   = '0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add  = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(BYTES_PER_WORD - 1))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_DONE:
            begin
                // A word without the last flag produces no result.
                if (!last_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // The output register fills on a result and empties when taken.
    always_comb
    begin
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // A result is never written over one that is still waiting.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || m_tready))
        else $error("dfh_ctrl: result loaded over a pending transaction");

    // An accepted word starts its first round with the byte count cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_MUL) && (cnt_reg == '0))
        else $error("dfh_ctrl: accepted word did not start at byte zero");

    // The eighth fold ends the word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ADD) && (cnt_reg == CNT_W'(BYTES_PER_WORD - 1))
        |=> state_reg == ST_DONE)
        else $error("dfh_ctrl: word did not finish after the last byte");

    // Products are always folded in the cycle after they are captured.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MUL |=> state_reg == ST_ADD)
        else $error("dfh_ctrl: multiply round not followed by its fold");

endmodule

// File: hw/rtl/dfh_datapath.sv
// Datapath of the dual FNV-1a word hasher: word shifter, two accumulator
// lanes with split 64-bit multipliers, and the output register.
// Depends on dfh_pkg for lane constants and the command struct.
module dfh_datapath
    import dfh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  dfh_cmd_t          cmd,
    input  logic [WORD_W-1:0] word,
    output logic [WORD_W-1:0] first_hash,
    output logic [WORD_W-1:0] second_hash
);

    logic [WORD_W-1:0] word_reg, word_next;
    logic [WORD_W-1:0] hash_out_reg [LANES];
    logic [WORD_W-1:0] acc_reg      [LANES];

    // The word is consumed from the low byte up, one byte per fold.
    always_comb
    begin
        priority if (cmd.load)
        begin
            word_next = word;
        end
        else if (cmd.add)
        begin
            word_next = word_reg >> BYTE_W;
        end
        else
        begin
            word_next = word_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    // One lane per hash: XOR in the byte, then multiply modulo 2^64 (capture, then sum).
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        logic [WORD_W-1:0] mix;
        logic [WORD_W-1:0] prod_ll;
        logic [HALF_W-1:0] prod_lh, prod_hl;
        logic [WORD_W-1:0] ll_reg;
        logic [HALF_W-1:0] lh_reg, hl_reg;
        logic [HALF_W-1:0] cross_sum;
        logic [WORD_W-1:0] acc_next;

        assign mix = acc_reg[g] ^ {{(WORD_W - BYTE_W){1'b0}}, word_reg[BYTE_W-1:0]};

        // Low 64 bits of the product need only three 32 by 32 partial products.
        // The cross terms only matter modulo 2^32, so they are kept at half width.
        assign prod_ll = mix[HALF_W-1:0] * LANE_PRIME[g][HALF_W-1:0];
        assign prod_lh = mix[HALF_W-1:0] * LANE_PRIME[g][WORD_W-1:HALF_W];
        assign prod_hl = mix[WORD_W-1:HALF_W] * LANE_PRIME[g][HALF_W-1:0];

        always_ff @(posedge clk)
        begin
            if (cmd.mul)
            begin
                ll_reg <= prod_ll;
                lh_reg <= prod_lh;
                hl_reg <= prod_hl;
            end
        end

        assign cross_sum = lh_reg + hl_reg;

        // Accumulator update: reload on start, fold on each round.
        always_comb
        begin
            priority if (cmd.load && cmd.start)
            begin
                acc_next = LANE_OFFSET[g];
            end
            else if (cmd.add)
            begin
                acc_next = ll_reg + {cross_sum, {HALF_W{1'b0}}};
            end
            else
            begin
                acc_next = acc_reg[g];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                acc_reg[g] <= LANE_OFFSET[g];
            end
            else
            begin
                acc_reg[g] <= acc_next;
            end
        end

        // Output register for this lane's hash.
        always_ff @(posedge clk)
        begin
            if (cmd.load_out)
            begin
                hash_out_reg[g] <= acc_reg[g];
            end
        end
    end

    assign first_hash  = hash_out_reg[0];
    assign second_hash = hash_out_reg[1];

endmodule
